// ----- design/gbtb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbtb_pkg
// Shared codes, constants and helpers of the GB2312 text box layout block.
// ----------------------------------------------------------------------------
package gbtb_pkg;

	localparam int KIND_W  = 3;
	localparam int GLYPH_W = 19;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_LEAD_HELD = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ASCII     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_HANZI     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BLANK     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BOX_FULL  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_BOX_LEFT   = 2'd0;
	localparam logic [1:0] REG_BOX_TOP    = 2'd1;
	localparam logic [1:0] REG_BOX_RIGHT  = 2'd2;
	localparam logic [1:0] REG_BOX_BOTTOM = 2'd3;

	localparam logic [7:0] LEAD_MIN   = 8'hA1;
	localparam logic [7:0] BYTE_BAD   = 8'hFF;
	localparam logic [7:0] ASCII_LIM  = 8'd128;
	localparam int         ROW_CODES  = 94;
	localparam int         HZ_BYTES   = 32;
	localparam int         ASC_BYTES  = 16;
	localparam int         CELL_WIDE  = 16;
	localparam int         CELL_NARROW = 8;

	typedef struct packed {
		logic       lead_pending;
		logic       box_full;
		logic [7:0] held_lead;
	} gbtb_flags_t;

	// HZK16 offset; both bytes are known to lie in 0xA1..0xFE here
	function automatic logic [GLYPH_W-1:0] hz_addr(input logic [7:0] lead,
		input logic [7:0] trail);
		logic [6:0]  row;
		logic [6:0]  col;
		logic [13:0] code;
		begin
			row  = 7'(lead - LEAD_MIN);
			col  = 7'(trail - LEAD_MIN);
			code = 14'(row) * 14'(ROW_CODES) + 14'(col);
			hz_addr = GLYPH_W'(code) * GLYPH_W'(HZ_BYTES);
		end
	endfunction

	function automatic logic [GLYPH_W-1:0] asc_addr(input logic [7:0] b);
		asc_addr = GLYPH_W'(b) * GLYPH_W'(ASC_BYTES);
	endfunction

endpackage
`default_nettype wire

// ----- design/gbtb_layout_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbtb_layout_step
// Next-state and result logic for one text byte against the current cursor.
// ----------------------------------------------------------------------------
module gbtb_layout_step #(
	parameter int COORD_BITS = 10,
	parameter int INDEX_BITS = 16
) (
	input  wire logic [COORD_BITS-1:0]    box_left,
	input  wire logic [COORD_BITS-1:0]    box_top,
	input  wire logic [COORD_BITS-1:0]    box_right,
	input  wire logic [COORD_BITS-1:0]    box_bottom,
	input  wire logic [7:0]               text_byte,
	input  wire logic                     first_of_text,
	input  wire logic                     last_of_text,
	input  wire logic [INDEX_BITS-1:0]    start_index,
	input  wire logic [COORD_BITS-1:0]    cur_x,
	input  wire logic [COORD_BITS-1:0]    cur_y,
	input  wire logic [INDEX_BITS-1:0]    cur_index,
	input  wire gbtb_pkg::gbtb_flags_t    cur_flags,
	output logic [COORD_BITS-1:0]         nxt_x,
	output logic [COORD_BITS-1:0]         nxt_y,
	output logic [INDEX_BITS-1:0]         nxt_index,
	output gbtb_pkg::gbtb_flags_t         nxt_flags,
	output logic [gbtb_pkg::KIND_W-1:0]   kind,
	output logic [gbtb_pkg::GLYPH_W-1:0]  glyph_address,
	output logic [COORD_BITS-1:0]         pos_x,
	output logic [COORD_BITS-1:0]         pos_y
);
	import gbtb_pkg::*;

	localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
	localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
	localparam logic [COORD_BITS:0]   WIDE_W    = (COORD_BITS+1)'(CELL_WIDE);
	localparam logic [COORD_BITS:0]   NARROW_W  = (COORD_BITS+1)'(CELL_NARROW);

	logic [COORD_BITS-1:0] x0, y0, x1, y1;
	logic [INDEX_BITS-1:0] idx0, idx_inc;
	gbtb_flags_t           f0;
	logic [COORD_BITS:0]   x0_wide, y0_wide, x1_wide, y1_wide, x1_narrow;
	logic                  wrap, full1, bad_trail;

	always_comb begin
		x0   = first_of_text ? box_left : cur_x;
		y0   = first_of_text ? box_top : cur_y;
		idx0 = first_of_text ? start_index : cur_index;
		f0   = first_of_text ? '0 : cur_flags;
	end

	assign idx_inc = (idx0 == INDEX_MAX) ? idx0 : idx0 + 1'b1;

	// wrap and full checks on the cursor after the first-of-text load
	assign x0_wide = {1'b0, x0} + WIDE_W;
	assign y0_wide = {1'b0, y0} + WIDE_W;
	assign wrap    = !f0.box_full && (x0_wide > {1'b0, box_right});

	always_comb begin
		x1 = wrap ? box_left : x0;
		y1 = wrap ? (y0_wide[COORD_BITS] ? COORD_MAX : y0_wide[COORD_BITS-1:0]) : y0;
	end

	assign x1_wide   = {1'b0, x1} + WIDE_W;
	assign y1_wide   = {1'b0, y1} + WIDE_W;
	assign x1_narrow = {1'b0, x1} + NARROW_W;
	assign full1     = f0.box_full || (y1_wide > {1'b0, box_bottom})
		|| (x1_wide > {1'b0, box_right});

	assign bad_trail = (text_byte < LEAD_MIN) || (text_byte == BYTE_BAD)
		|| (f0.held_lead == BYTE_BAD);

	always_comb begin
		nxt_x         = x0;
		nxt_y         = y0;
		nxt_index     = idx0;
		nxt_flags     = f0;
		kind          = KIND_DROPPED;
		glyph_address = '0;
		pos_x         = x0;
		pos_y         = y0;
		priority if (f0.lead_pending) begin
			nxt_flags.lead_pending = 1'b0;
			nxt_flags.held_lead    = '0;
			nxt_index              = idx_inc;
			if (!bad_trail) begin
				kind          = KIND_HANZI;
				glyph_address = hz_addr(f0.held_lead, text_byte);
				nxt_x = x0_wide[COORD_BITS] ? COORD_MAX : x0_wide[COORD_BITS-1:0];
			end
		end else if (full1) begin
			nxt_x             = x1;
			nxt_y             = y1;
			nxt_flags.box_full = 1'b1;
			kind              = KIND_BOX_FULL;
			pos_x             = x1;
			pos_y             = y1;
		end else if (text_byte >= LEAD_MIN) begin
			nxt_x     = x1;
			nxt_y     = y1;
			nxt_index = idx_inc;
			pos_x     = x1;
			pos_y     = y1;
			if (!last_of_text) begin
				kind                   = KIND_LEAD_HELD;
				nxt_flags.lead_pending = 1'b1;
				nxt_flags.held_lead    = text_byte;
			end
		end else begin
			nxt_x     = x1_narrow[COORD_BITS] ? COORD_MAX : x1_narrow[COORD_BITS-1:0];
			nxt_y     = y1;
			nxt_index = idx_inc;
			pos_x     = x1;
			pos_y     = y1;
			if (text_byte < ASCII_LIM) begin
				kind          = KIND_ASCII;
				glyph_address = asc_addr(text_byte);
			end else begin
				kind = KIND_BLANK;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/gb2312_text_box_layout_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gb2312_text_box_layout_top
// Lays out mixed ASCII / GB2312 text bytes into a configured rectangle and
// reports the ASC16 / HZK16 glyph address and cell position of each byte.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           contents
//  s_*       in         s_tvalid/s_tready   text byte, start index, first, last
//  m_*       out        m_tvalid/m_tready   kind, glyph address, x, y, next index
//  cfg_*     in         cfg_valid/cfg_ready box edge register writes
//
//  one byte per cycle sustained while the m side does not stall; the result
//  is registered (input register, then layout logic into the result register).
//  the cursor state updates as a byte leaves the input register, so bytes
//  follow each other with no gap.
//  reset clears cursor, index and flags and loads the box to 0,0,159,95.
//  a stalled m side holds the result; s_tready drops only when both stages
//  are full. configuration writes are always taken.
// ----------------------------------------------------------------------------
module gb2312_text_box_layout_top #(
	parameter int COORD_BITS = 10,
	parameter int INDEX_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [COORD_BITS-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// text_byte [7:0], start_index above it, zero padded
	input  wire logic [((8+INDEX_BITS+7)/8)*8-1:0] s_tdata,
	// first_of_text
	input  wire logic                  s_tuser,
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// glyph_address [18:0], pos_x, pos_y, next_index, zero padded
	output logic [((gbtb_pkg::GLYPH_W+2*COORD_BITS+INDEX_BITS+7)/8)*8-1:0] m_tdata,
	// kind
	output logic [gbtb_pkg::KIND_W-1:0] m_tuser
);
	import gbtb_pkg::*;

	localparam int OUT_FIELDS = GLYPH_W + 2*COORD_BITS + INDEX_BITS;
	localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8;

	logic [COORD_BITS-1:0] box_left_q, box_top_q, box_right_q, box_bottom_q;
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, nxt_x, nxt_y;
	logic [INDEX_BITS-1:0] cur_index_q, nxt_index;
	gbtb_flags_t           flags_q, nxt_flags;

	logic                  valid_s1, first_s1, last_s1;
	logic [7:0]            byte_s1;
	logic [INDEX_BITS-1:0] start_s1;

	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q, kind_c;
	logic [GLYPH_W-1:0]    glyph_q, glyph_c;
	logic [COORD_BITS-1:0] pos_x_q, pos_y_q, pos_x_c, pos_y_c;
	logic [INDEX_BITS-1:0] next_index_q;
	logic                  advance;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= '0;
			box_top_q    <= '0;
			box_right_q  <= COORD_BITS'(159);
			box_bottom_q <= COORD_BITS'(95);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BOX_LEFT:   box_left_q   <= cfg_data;
				REG_BOX_TOP:    box_top_q    <= cfg_data;
				REG_BOX_RIGHT:  box_right_q  <= cfg_data;
				REG_BOX_BOTTOM: box_bottom_q <= cfg_data;
				default:        box_left_q   <= box_left_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata[7:0];
			start_s1 <= s_tdata[8 +: INDEX_BITS];
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	gbtb_layout_step #(
		.COORD_BITS(COORD_BITS),
		.INDEX_BITS(INDEX_BITS)
	) u_step (
		.box_left      (box_left_q),
		.box_top       (box_top_q),
		.box_right     (box_right_q),
		.box_bottom    (box_bottom_q),
		.text_byte     (byte_s1),
		.first_of_text (first_s1),
		.last_of_text  (last_s1),
		.start_index   (start_s1),
		.cur_x         (cur_x_q),
		.cur_y         (cur_y_q),
		.cur_index     (cur_index_q),
		.cur_flags     (flags_q),
		.nxt_x         (nxt_x),
		.nxt_y         (nxt_y),
		.nxt_index     (nxt_index),
		.nxt_flags     (nxt_flags),
		.kind          (kind_c),
		.glyph_address (glyph_c),
		.pos_x         (pos_x_c),
		.pos_y         (pos_y_c)
	);

	// cursor state and result valid move on the transfer out of stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cur_index_q <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				cur_x_q     <= nxt_x;
				cur_y_q     <= nxt_y;
				cur_index_q <= nxt_index;
				flags_q     <= nxt_flags;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			kind_q       <= kind_c;
			glyph_q      <= glyph_c;
			pos_x_q      <= pos_x_c;
			pos_y_q      <= pos_y_c;
			next_index_q <= nxt_index;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = OUT_W'({next_index_q, pos_y_q, pos_x_q, glyph_q});

endmodule
`default_nettype wire
